[hw/rtl/dnw_pkg.sv]
// dnw_pkg: shared types, constants and the character check for the dns name encoder
// used by every module and interface of the block but dnw_ram; no dependencies

package dnw_pkg;

  // name limits
  localparam int unsigned MAX_LABEL   = 63;
  localparam int unsigned MAX_NAME    = 255;
  localparam int unsigned LABEL_DEPTH = 63;

  // field and counter widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LBL_W  = 6;
  localparam int unsigned NAME_W = 8;
  localparam int unsigned SUM_W  = NAME_W + 1;

  // characters with a special meaning
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR_END,
    S_ERR_MID,
    S_ROOT,
    S_LEN,
    S_DATA
  } state_t;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_STORE,
    OP_CLEAR,
    OP_START,
    OP_ERR_END,
    OP_ERR_MID,
    OP_ROOT,
    OP_LEN,
    OP_DATA
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic failed;
    logic at_end;
    logic is_dot;
    logic lbl_zero;
    logic lbl_full;
    logic char_bad;
    logic over_dot;
    logic over_end;
    logic over_root;
    logic name_zero;
    logic idx_last;
    logic out_free;
  } status_t;

  // accepted host name characters; a hyphen may not open a label
  function automatic logic char_ok(input logic [BYTE_W-1:0] c, input logic first);
    logic ok;
    ok = 1'b0;
    if (c >= 8'h61 && c <= 8'h7A) ok = 1'b1;
    if (c >= 8'h41 && c <= 8'h5A) ok = 1'b1;
    if (c >= 8'h30 && c <= 8'h39) ok = 1'b1;
    if (c == CH_UNDER) ok = 1'b1;
    if (c == CH_DASH && !first) ok = 1'b1;
    return ok;
  endfunction

endpackage

[hw/rtl/dnw_in_if.sv]
// dnw_in_if: character channel, valid/ready handshake with char and end marker
// depends on dnw_pkg

interface dnw_in_if;
  logic                        valid;
  logic                        ready;
  logic [dnw_pkg::BYTE_W-1:0]  char_byte;
  logic                        end_of_name;

  modport source (output valid, output char_byte, output end_of_name, input ready);
  modport sink   (input valid, input char_byte, input end_of_name, output ready);
endinterface

[hw/rtl/dnw_out_if.sv]
// dnw_out_if: wire-format byte channel, valid/ready handshake
// depends on dnw_pkg

interface dnw_out_if;
  logic                        valid;
  logic                        ready;
  logic [dnw_pkg::BYTE_W-1:0]  out_byte;
  logic                        root_after;
  logic                        last;
  logic                        error;

  modport source (output valid, output out_byte, output root_after, output last,
                  output error, input ready);
  modport sink   (input valid, input out_byte, input root_after, input last,
                  input error, output ready);
endinterface

[hw/rtl/dnw_ram.sv]
// dnw_ram: generic single write port, single read port ram with registered read
// no dependencies

module dnw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/dnw_ctrl.sv]
// dnw_ctrl: controller state machine, decides per transaction and sequences label flushes
// depends on dnw_pkg

module dnw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dnw_pkg::status_t status,
  output dnw_pkg::cmd_t    cmd
);

  dnw_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dnw_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.op    = dnw_pkg::OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      dnw_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.failed) begin
            // swallow the rest of a failed name
            if (status.at_end) cmd.op = dnw_pkg::OP_CLEAR;
          end else if (status.at_end) begin
            if (!status.lbl_zero) begin
              if (status.over_end) begin
                state_nxt = dnw_pkg::S_ERR_END;
              end else begin
                cmd.op    = dnw_pkg::OP_START;
                state_nxt = dnw_pkg::S_LEN;
              end
            end else if (status.name_zero || status.over_root) begin
              state_nxt = dnw_pkg::S_ERR_END;
            end else begin
              state_nxt = dnw_pkg::S_ROOT;
            end
          end else if (status.is_dot) begin
            if (status.lbl_zero || status.over_dot) begin
              state_nxt = dnw_pkg::S_ERR_MID;
            end else begin
              cmd.op    = dnw_pkg::OP_START;
              state_nxt = dnw_pkg::S_LEN;
            end
          end else if (status.lbl_full || status.char_bad) begin
            state_nxt = dnw_pkg::S_ERR_MID;
          end else begin
            cmd.op = dnw_pkg::OP_STORE;
          end
        end
      end
      dnw_pkg::S_ERR_END: begin
        if (status.out_free) begin
          cmd.op    = dnw_pkg::OP_ERR_END;
          state_nxt = dnw_pkg::S_IDLE;
        end
      end
      dnw_pkg::S_ERR_MID: begin
        if (status.out_free) begin
          cmd.op    = dnw_pkg::OP_ERR_MID;
          state_nxt = dnw_pkg::S_IDLE;
        end
      end
      dnw_pkg::S_ROOT: begin
        if (status.out_free) begin
          cmd.op    = dnw_pkg::OP_ROOT;
          state_nxt = dnw_pkg::S_IDLE;
        end
      end
      dnw_pkg::S_LEN: begin
        if (status.out_free) begin
          cmd.op    = dnw_pkg::OP_LEN;
          state_nxt = dnw_pkg::S_DATA;
        end
      end
      dnw_pkg::S_DATA: begin
        if (status.out_free) begin
          cmd.op = dnw_pkg::OP_DATA;
          if (status.idx_last) state_nxt = dnw_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dnw_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // a flush only runs over a non-empty label
  a_flush_has_label: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dnw_pkg::S_LEN || state_r == dnw_pkg::S_DATA) |-> !status.lbl_zero)
    else $error("flush sequencing with an empty label");
`endif

endmodule

[hw/rtl/dnw_dp.sv]
// dnw_dp: datapath with label store, counters, checks and the output register
// depends on dnw_pkg and dnw_ram

module dnw_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [dnw_pkg::BYTE_W-1:0] in_char,
  input  logic                       in_end,
  input  dnw_pkg::cmd_t              cmd,
  output dnw_pkg::status_t           status,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dnw_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_root,
  output logic                       out_last,
  output logic                       out_error
);

  localparam logic [dnw_pkg::SUM_W-1:0] MAX_NAME_S = dnw_pkg::SUM_W'(dnw_pkg::MAX_NAME);
  localparam logic [dnw_pkg::LBL_W-1:0] MAX_LBL_S  = dnw_pkg::LBL_W'(dnw_pkg::MAX_LABEL);

  logic [dnw_pkg::LBL_W-1:0]  label_count_r, label_count_nxt;
  logic [dnw_pkg::NAME_W-1:0] name_count_r, name_count_nxt;
  logic                       failed_r, failed_nxt;
  logic                       end_r, end_nxt;
  logic [dnw_pkg::LBL_W-1:0]  idx_r, idx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [dnw_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                       out_root_r, out_root_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_error_r, out_error_nxt;
  logic                       load;

  logic                       wr_en;
  logic                       rd_en;
  logic [dnw_pkg::LBL_W-1:0]  rd_addr;
  logic [dnw_pkg::BYTE_W-1:0] rd_data;

  logic [dnw_pkg::SUM_W-1:0]  base_sum;
  logic                       idx_last;

  // label store
  dnw_ram #(
    .WIDTH (dnw_pkg::BYTE_W),
    .DEPTH (dnw_pkg::LABEL_DEPTH)
  ) u_label_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (label_count_r),
    .wr_data (in_char),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // length checks and status
  assign base_sum = dnw_pkg::SUM_W'(name_count_r) + dnw_pkg::SUM_W'(label_count_r);
  assign idx_last = (idx_r + 1'b1) == label_count_r;

  always_comb begin
    status.failed    = failed_r;
    status.at_end    = in_end;
    status.is_dot    = in_char == dnw_pkg::CH_DOT;
    status.lbl_zero  = label_count_r == '0;
    status.lbl_full  = label_count_r >= MAX_LBL_S;
    status.char_bad  = !dnw_pkg::char_ok(in_char, label_count_r == '0);
    status.over_dot  = (base_sum + dnw_pkg::SUM_W'(1)) > MAX_NAME_S;
    status.over_end  = (base_sum + dnw_pkg::SUM_W'(2)) > MAX_NAME_S;
    status.over_root = (dnw_pkg::SUM_W'(name_count_r) + dnw_pkg::SUM_W'(1)) > MAX_NAME_S;
    status.name_zero = name_count_r == '0;
    status.idx_last  = idx_last;
    status.out_free  = !out_valid_r || out_ready;
  end

  // operation decode
  always_comb begin
    label_count_nxt = label_count_r;
    name_count_nxt  = name_count_r;
    failed_nxt      = failed_r;
    end_nxt         = end_r;
    idx_nxt         = idx_r;
    out_byte_nxt    = out_byte_r;
    out_root_nxt    = out_root_r;
    out_last_nxt    = out_last_r;
    out_error_nxt   = out_error_r;
    load            = 1'b0;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = idx_r;
    unique case (cmd.op)
      dnw_pkg::OP_NONE: begin
      end
      dnw_pkg::OP_STORE: begin
        wr_en           = 1'b1;
        label_count_nxt = label_count_r + 1'b1;
      end
      dnw_pkg::OP_CLEAR: begin
        label_count_nxt = '0;
        name_count_nxt  = '0;
        failed_nxt      = 1'b0;
      end
      dnw_pkg::OP_START: begin
        end_nxt = in_end;
      end
      dnw_pkg::OP_ERR_END, dnw_pkg::OP_ERR_MID: begin
        load            = 1'b1;
        out_byte_nxt    = '0;
        out_root_nxt    = 1'b0;
        out_last_nxt    = 1'b1;
        out_error_nxt   = 1'b1;
        label_count_nxt = '0;
        name_count_nxt  = '0;
        failed_nxt      = cmd.op == dnw_pkg::OP_ERR_MID;
      end
      dnw_pkg::OP_ROOT: begin
        // trailing dot: root byte alone
        load            = 1'b1;
        out_byte_nxt    = '0;
        out_root_nxt    = 1'b0;
        out_last_nxt    = 1'b1;
        out_error_nxt   = 1'b0;
        label_count_nxt = '0;
        name_count_nxt  = '0;
        failed_nxt      = 1'b0;
      end
      dnw_pkg::OP_LEN: begin
        load          = 1'b1;
        out_byte_nxt  = dnw_pkg::BYTE_W'(label_count_r);
        out_root_nxt  = 1'b0;
        out_last_nxt  = 1'b0;
        out_error_nxt = 1'b0;
        rd_en         = 1'b1;
        rd_addr       = '0;
        idx_nxt       = '0;
      end
      dnw_pkg::OP_DATA: begin
        load          = 1'b1;
        out_byte_nxt  = rd_data;
        out_root_nxt  = end_r && idx_last;
        out_last_nxt  = idx_last;
        out_error_nxt = 1'b0;
        if (idx_last) begin
          label_count_nxt = '0;
          if (end_r) begin
            name_count_nxt = '0;
            failed_nxt     = 1'b0;
          end else begin
            name_count_nxt = name_count_r + dnw_pkg::NAME_W'(label_count_r) + 1'b1;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
          rd_en   = 1'b1;
          rd_addr = idx_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_count_r <= '0;
      name_count_r  <= '0;
      failed_r      <= 1'b0;
      end_r         <= 1'b0;
      idx_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      label_count_r <= label_count_nxt;
      name_count_r  <= name_count_nxt;
      failed_r      <= failed_nxt;
      end_r         <= end_nxt;
      idx_r         <= idx_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    out_root_r  <= out_root_nxt;
    out_last_r  <= out_last_nxt;
    out_error_r <= out_error_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_root  = out_root_r;
  assign out_last  = out_last_r;
  assign out_error = out_error_r;

`ifndef SYNTHESIS
  // a failed name holds no buffered or counted bytes
  a_failed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> (label_count_r == '0 && name_count_r == '0))
    else $error("failed name still holds bytes");

  // the final byte of a terminated name leaves the counters clear
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == dnw_pkg::OP_DATA && idx_last && end_r) |=>
      (name_count_r == '0 && label_count_r == '0))
    else $error("counters not cleared after name end");

  // a result is never overwritten while waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !load)
    else $error("output register overwritten under stall");
`endif

endmodule

[hw/rtl/dns_name_dot_to_wire_top.sv]
// dns_name_dot_to_wire_top: dotted host name to dns wire form encoder, top level
// depends on dnw_pkg, dnw_in_if, dnw_out_if, dnw_ctrl, dnw_dp, dnw_ram
//
//   channel   direction  payload                                  handshake
//   in_ch     sink       char_byte[7:0], end_of_name              valid/ready
//   out_ch    source     out_byte[7:0], root_after, last, error   valid/ready
//
// a plain character is accepted and yields no result
// a flush takes the accept, then the length byte and n label bytes one per cycle while the
// output is free, then the next accept; the label store read port gives them at that rate
// an error or a lone root byte takes the accept, then the result once the output is free
// reset is synchronous, active low; the label store needs no clearing
// a stalled output holds the result register; plain characters are still taken, and the
// next transaction that yields a result is accepted and then waits for the output

module dns_name_dot_to_wire_top (
  input  logic     clk,
  input  logic     rst_n,
  dnw_in_if.sink   in_ch,
  dnw_out_if.source out_ch
);

  dnw_pkg::cmd_t    cmd;
  dnw_pkg::status_t status;

  dnw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  dnw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_char   (in_ch.char_byte),
    .in_end    (in_ch.end_of_name),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_root  (out_ch.root_after),
    .out_last  (out_ch.last),
    .out_error (out_ch.error)
  );

endmodule

[bench/tb_dns_name_dot_to_wire_top.sv]
// tb_dns_name_dot_to_wire_top: self-checking bench for the dotted name to dns wire encoder
// drives dnw_in_if transactions, predicts wire bytes, checks them on dnw_out_if
// depends on dnw_pkg, dnw_in_if, dnw_out_if and dns_name_dot_to_wire_top

`timescale 1ns / 1ps

module tb_dns_name_dot_to_wire_top;
  import dnw_pkg::*;

  // one wire-format result
  typedef struct packed {
    logic [BYTE_W-1:0] val;
    logic              root;
    logic              last;
    logic              err;
  } wire_res_t;

  // one input transaction, with an optional hand-written expectation
  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              eon;
    logic              typed;
    wire_res_t         want;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n;

  dnw_in_if  in_ch ();
  dnw_out_if out_ch ();

  dns_name_dot_to_wire_top uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  stim_t     stim_q [$];
  wire_res_t wire_q [$];
  wire_res_t step_res [$];
  int        fail_cnt = 0;

  // encoder state as the bench sees it
  logic [BYTE_W-1:0] lbl_buf [LABEL_DEPTH];
  int                lbl_len;
  int                wire_len;
  bit                swallowing;

  // ---------------------------------------------------------------- predictor

  function automatic bit host_char(input logic [BYTE_W-1:0] c, input bit first);
    if (c >= "a" && c <= "z") return 1'b1;
    if (c >= "A" && c <= "Z") return 1'b1;
    if (c >= "0" && c <= "9") return 1'b1;
    if (c == CH_UNDER) return 1'b1;
    return (c == CH_DASH) && !first;
  endfunction

  task automatic push_res(input logic [BYTE_W-1:0] v, input logic r, input logic l,
                          input logic e);
    wire_res_t w;
    w.val  = v;
    w.root = r;
    w.last = l;
    w.err  = e;
    step_res.push_back(w);
  endtask

  // length byte then the buffered label
  task automatic emit_label(input bit root);
    push_res(8'(lbl_len), 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < lbl_len; i++)
      push_res(lbl_buf[i], root && (i == lbl_len - 1), i == lbl_len - 1, 1'b0);
    wire_len = wire_len + lbl_len + 1;
    lbl_len  = 0;
  endtask

  task automatic report_bad(input bit at_end);
    push_res('0, 1'b0, 1'b1, 1'b1);
    lbl_len    = 0;
    wire_len   = 0;
    swallowing = !at_end;
  endtask

  task automatic encode_step(input logic [BYTE_W-1:0] ch, input logic eon);
    step_res.delete();
    if (swallowing) begin
      if (eon) begin
        swallowing = 1'b0;
        lbl_len    = 0;
        wire_len   = 0;
      end
    end else if (eon) begin
      if (lbl_len > 0) begin
        if (wire_len + lbl_len + 2 > MAX_NAME) report_bad(1'b1);
        else begin
          emit_label(1'b1);
          wire_len = 0;
        end
      end else if (wire_len == 0 || wire_len + 1 > MAX_NAME) begin
        report_bad(1'b1);
      end else begin
        // trailing dot: root byte stands alone
        push_res('0, 1'b0, 1'b1, 1'b0);
        wire_len = 0;
      end
    end else if (ch == CH_DOT) begin
      if (lbl_len == 0 || wire_len + lbl_len + 1 > MAX_NAME) report_bad(1'b0);
      else emit_label(1'b0);
    end else if (lbl_len >= MAX_LABEL || !host_char(ch, lbl_len == 0)) begin
      report_bad(1'b0);
    end else begin
      lbl_buf[lbl_len] = ch;
      lbl_len++;
    end
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  function automatic stim_t row(input logic [BYTE_W-1:0] c, input logic e);
    stim_t s;
    s     = '0;
    s.ch  = c;
    s.eon = e;
    return s;
  endfunction

  function automatic stim_t row_want(input logic [BYTE_W-1:0] c, input logic e,
                                     input logic [BYTE_W-1:0] v, input logic r,
                                     input logic l, input logic x);
    stim_t s;
    s           = row(c, e);
    s.typed     = 1'b1;
    s.want.val  = v;
    s.want.root = r;
    s.want.last = l;
    s.want.err  = x;
    return s;
  endfunction

  task automatic add_item(input logic [BYTE_W-1:0] c, input logic e);
    stim_q.push_back(row(c, e));
  endtask

  function automatic logic [BYTE_W-1:0] pick_host_char(input bit first);
    case ($urandom_range(0, first ? 3 : 4))
      0:       return 8'("a" + $urandom_range(0, 25));
      1:       return 8'("A" + $urandom_range(0, 25));
      2:       return 8'("0" + $urandom_range(0, 9));
      3:       return CH_UNDER;
      default: return CH_DASH;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_bad_char();
    logic [BYTE_W-1:0] c;
    c = 8'($urandom_range(0, 255));
    while (host_char(c, 1'b0) || c == CH_DOT) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic add_label(input int len);
    for (int i = 0; i < len; i++) add_item(pick_host_char(i == 0), 1'b0);
  endtask

  // end marker carries a random, ignored character
  task automatic add_end();
    add_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // ---------------------------------------------------------------- input side

  stim_t cur_item;
  int    burst_left;
  int    gap_left;

  // sender: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left  = 0;
      gap_left    = 0;
      swallowing  = 1'b0;
      lbl_len     = 0;
      wire_len    = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        encode_step(cur_item.ch, cur_item.eon);
        if (cur_item.typed) wire_q.push_back(cur_item.want);
        else foreach (step_res[i]) wire_q.push_back(step_res[i]);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered transaction
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (stim_q.size() > 0) begin
        cur_item = stim_q.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.char_byte   <= cur_item.ch;
        in_ch.end_of_name <= cur_item.eon;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- output side

  int stall_mode;
  int phase_left;
  int hold_left;
  bit hold_done;
  int rcv_cnt;
  int pat_cnt;

  // receiver: stall pattern of its own, plus one long hold-off to back up the block
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_mode   = 0;
      phase_left   = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
      rcv_cnt      = 0;
      pat_cnt      = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) rcv_cnt++;
      pat_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && rcv_cnt >= 60) begin
        hold_done = 1'b1;
        hold_left = 400;
        out_ch.ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          phase_left = $urandom_range(20, 80);
        end else begin
          phase_left--;
        end
        case (stall_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (pat_cnt % 5 != 0);
        endcase
      end
    end
  end

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_cnt++;
    end
  endtask

  wire_res_t want_res;

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (wire_q.size() == 0) begin
        $display({"%0t ns: unexpected result, expected none, ",
                  "actual byte %0h root %0b last %0b err %0b"},
                 $time, out_ch.out_byte, out_ch.root_after, out_ch.last, out_ch.error);
        fail_cnt++;
      end else begin
        want_res = wire_q.pop_front();
        check_field("out_byte", want_res.val, out_ch.out_byte);
        check_field("root_after", want_res.root, out_ch.root_after);
        check_field("last", want_res.last, out_ch.last);
        check_field("error", want_res.err, out_ch.error);
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  stim_t plan [25];
  int    rand_items;
  int    n0;
  int    kind;
  int    labels;

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.char_byte    = '0;
    in_ch.end_of_name  = 1'b0;
    out_ch.ready       = 1'b0;

    // directed: empty name, empty label, leading hyphen, bad characters, trailing dot, ignored end character
    plan = '{
      row_want(8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1),   // empty name
      row("a", 1'b0),
      row(CH_DOT, 1'b0),
      row_want(8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0),   // trailing dot
      row_want(CH_DOT, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1),  // empty label
      row("q", 1'b0),
      row(8'h00, 1'b1),
      row_want(CH_DASH, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1), // hyphen opens label
      row(8'h00, 1'b1),
      row("Z", 1'b0),
      row(CH_DASH, 1'b0),
      row("9", 1'b0),
      row(CH_UNDER, 1'b0),
      row(8'hFF, 1'b1),
      row_want(8'hFF, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1),   // bad character, all ones
      row(8'h00, 1'b1),
      row_want(8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1),   // bad character, all zeros
      row(8'h00, 1'b1),
      row("0", 1'b0),
      row("z", 1'b0),
      row(CH_DOT, 1'b0),
      row("A", 1'b0),
      row(CH_DOT, 1'b1),
      row_want("/", 1'b0, 8'h00, 1'b0, 1'b1, 1'b1),     // bad character
      row(8'h00, 1'b1)
    };
    foreach (plan[i]) stim_q.push_back(plan[i]);

    // random names, mostly well formed
    rand_items = 0;
    while (rand_items < 225) begin
      n0   = stim_q.size();
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        labels = $urandom_range(1, 4);
        for (int j = 0; j < labels; j++) begin
          add_label(($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 8));
          if (j < labels - 1) add_item(CH_DOT, 1'b0);
        end
        if ($urandom_range(0, 3) == 0) add_item(CH_DOT, 1'b0);
        add_end();
      end else if (kind < 75) begin
        // one fault inside an otherwise sane name
        add_label($urandom_range(1, 6));
        case ($urandom_range(0, 2))
          0: begin
            add_item(CH_DOT, 1'b0);
            add_item(CH_DOT, 1'b0);
          end
          1: begin
            add_item(CH_DOT, 1'b0);
            add_item(CH_DASH, 1'b0);
          end
          default: add_item(pick_bad_char(), 1'b0);
        endcase
        add_label($urandom_range(0, 5));
        add_end();
      end else if (kind < 85) begin
        // raw bytes with stray end markers
        repeat ($urandom_range(1, 12))
          add_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        add_end();
      end else if (kind < 92) begin
        // label around the length limit
        add_label($urandom_range(61, 64));
        add_end();
      end else begin
        if ($urandom_range(0, 1) == 1) add_item(CH_DOT, 1'b0);
        add_end();
      end
      rand_items += stim_q.size() - n0;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all transactions in and all results out, then drain
    @(negedge clk);
    while (stim_q.size() != 0 || in_ch.valid || wire_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/dnw_pkg.sv
hw/rtl/dnw_in_if.sv
hw/rtl/dnw_out_if.sv
hw/rtl/dnw_ram.sv
hw/rtl/dnw_ctrl.sv
hw/rtl/dnw_dp.sv
hw/rtl/dns_name_dot_to_wire_top.sv
bench/tb_dns_name_dot_to_wire_top.sv
